/* sv/tssg_pkg.sv */
// shared types and constants of the tone sequence sine generator
package tssg_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_START  = 3'd2,
      OP_TICK   = 3'd3,
      OP_ABORT  = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FETCH,
      S_READ,
      S_LEN,
      S_LENW,
      S_STEPW,
      S_SAMP,
      S_X,
      S_X2M,
      S_X2,
      S_TM,
      S_TD,
      S_TW,
      S_MAG,
      S_MAG2,
      S_VOL,
      S_OUT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
   localparam logic [17:0] RATE_RESET   = 18'd48000;
   localparam logic [16:0] VOL_RESET    = 17'd39322;
   localparam logic [16:0] VOL_FULL     = 17'd65536;
   localparam logic [17:0] MS_PER_S     = 18'd1000;
   localparam logic [9:0]  MS_ROUND     = 10'd500;
   localparam logic [14:0] SINE_PEAK    = 15'd32767;
   localparam logic [2:0]  SERIES_TERMS = 3'd6;
   localparam logic        CSR_RATE     = 1'b0;
   localparam logic        CSR_VOLUME   = 1'b1;

   // taylor series divisors (2n)(2n+1)
   function automatic logic [7:0] series_div(input logic [2:0] n);
      logic [7:0] d;
      case (n)
         3'd1:    d = 8'd6;
         3'd2:    d = 8'd20;
         3'd3:    d = 8'd42;
         3'd4:    d = 8'd72;
         3'd5:    d = 8'd110;
         3'd6:    d = 8'd156;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

endpackage

/* sv/tssg_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module tssg_div #(
   parameter int DVD_W = 49,
   parameter int DVR_W = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DVD_W-1:0]       dividend,
   input  logic [DVR_W-1:0]       divisor,
   output logic [DVD_W-1:0]       quotient,
   output tssg_pkg::div_stat_type stat
);
   import tssg_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVR_W-1:0] dvr_ff, dvr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVR_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvr_in  = dvr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         rem_in = fits ? DVR_W'(trial - {1'b0, dvr_ff}) : trial[DVR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvr_ff <= dvr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* sv/tone_sequence_sine_generator_top.sv */
// top level of the tone sequence sine generator
// usage:
//   req channel (req_valid / req_stall) carries one command beat: op, freq_hz,
//   length_ms. ops are clear list, append tone, start, sample tick, abort.
//   rsp channel (rsp_valid / rsp_stall) carries sample and done_res; at most
//   one rsp beat per req beat (ticks while playing, abort while playing).
//   csr port writes the output rate (index 0) or volume (index 1) with csr_we.
// per command:
//   clear, append, start, ignored ops and idle ticks: no beat.
//   abort while playing: one beat.
//   a tick inside a tone runs the six serial divides of the sine series in the
//   shared bit-serial divider (DIV_W = PHASE_BITS + 17, at least 35).
//   a tick that loads a new tone adds the length and phase step divides;
//   each skipped zero-length entry adds a length divide.
//   a silent tone sample skips the series; the end of the list and an end
//   marker each give a done beat.
//   one command at a time: req_stall stays high until the beat is handed over.
// reset: synchronous; tone list empty, idle, registers at their reset values.
// stall: a finished beat waits in the rsp register; the next command is taken
//   meanwhile, and a further result waits until the register frees.
module tone_sequence_sine_generator_top #(
   parameter int TONE_DEPTH  = 64,
   parameter int SINE_POINTS = 4096,
   parameter int PHASE_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [15:0]         req_freq_hz,
   input  logic [15:0]         req_length_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_sample,
   output logic                rsp_done_res,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [17:0]         csr_wdata
);
   import tssg_pkg::*;

   localparam int IDX_W = $clog2(TONE_DEPTH);
   localparam int CNT_W = $clog2(TONE_DEPTH + 1);
   localparam int SB    = $clog2(SINE_POINTS);
   localparam int PB    = PHASE_BITS;
   localparam int DIV_W = (PB + 17 > 35) ? PB + 17 : 35;

   // tone list memory
   logic [15:0] freq_mem [TONE_DEPTH];
   logic [15:0] dur_mem  [TONE_DEPTH];
   logic [15:0] rd_freq_ff, rd_dur_ff;

   // configuration
   logic [17:0] rate_ff;
   logic [16:0] vol_ff;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pidx_ff, pidx_in;
   logic [PB-1:0]     acc_ff, acc_in;
   logic [PB-1:0]     step_ff, step_in;
   logic [23:0]       left_ff, left_in;
   logic              playing_ff, playing_in;
   logic              silent_ff, silent_in;
   logic [1:0]        quad_ff, quad_in;
   logic [31:0]       x2_ff, x2_in;
   logic [31:0]       term_ff, term_in;
   logic signed [33:0] sum_ff, sum_in;
   logic [2:0]        n_ff, n_in;
   logic [14:0]       mag_ff, mag_in;
   logic [63:0]       prod_ff;
   logic [15:0]       res_sample_ff, res_sample_in;
   logic              res_done_ff, res_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_sample_ff, rsp_sample_in;
   logic              rsp_done_ff, rsp_done_in;

   // combinational controls
   logic              accept;
   logic              mem_we;
   logic              mem_re;
   logic [31:0]       mul_a, mul_b;
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [17:0]       div_divisor;
   logic [DIV_W-1:0]  div_quotient;
   div_stat_type      div_stat;
   logic              out_free;

   // sine argument from the phase
   logic [SB-1:0]     sidx;
   logic [SB:0]       rlo, rarg;
   logic [16:0]       vol_eff;
   logic [33:0]       mag_round;
   logic [14:0]       mag_res;
   logic [23:0]       len_val;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sidx     = acc_ff[PB-1 -: SB];
   assign rlo      = {1'b0, sidx[SB-3:0], 2'b00};
   assign rarg     = sidx[SB-2] ? ((SB+1)'(SINE_POINTS) - rlo) : rlo;
   assign vol_eff  = (vol_ff > VOL_FULL) ? VOL_FULL : vol_ff;
   assign mag_round = prod_ff[63:30] + 34'd0 + ((prod_ff[29:0] + 30'h2000_0000) < prod_ff[29:0]
                      ? 34'd1 : 34'd0);
   assign mag_res  = (mag_round > 34'(SINE_PEAK)) ? SINE_PEAK : mag_round[14:0];
   assign len_val  = (div_quotient[DIV_W-1:24] != '0) ? 24'hFF_FFFF : div_quotient[23:0];

   tssg_div #(
      .DVD_W (DIV_W),
      .DVR_W (18)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_ABORT && playing_ff) begin
                  state_in = S_EMIT;
               end else if (req_op == OP_TICK && playing_ff) begin
                  state_in = (left_ff == '0) ? S_FETCH : S_SAMP;
               end
            end
         end
         S_FETCH: state_in = (pidx_ff < count_ff) ? S_READ : S_EMIT;
         S_READ:  state_in = (rd_freq_ff == '0 && rd_dur_ff == '0) ? S_EMIT : S_LEN;
         S_LEN:   state_in = S_LENW;
         S_LENW: begin
            if (div_stat.done) begin
               state_in = (len_val == '0) ? S_FETCH : S_STEPW;
            end
         end
         S_STEPW: if (div_stat.done) state_in = S_SAMP;
         S_SAMP:  state_in = silent_ff ? S_EMIT : S_X;
         S_X:     state_in = S_X2M;
         S_X2M:   state_in = S_X2;
         S_X2:    state_in = S_TM;
         S_TM:    state_in = S_TD;
         S_TD:    state_in = S_TW;
         S_TW: begin
            if (div_stat.done) begin
               state_in = (n_ff == SERIES_TERMS) ? S_MAG : S_TM;
            end
         end
         S_MAG:   state_in = S_MAG2;
         S_MAG2:  state_in = S_VOL;
         S_VOL:   state_in = S_OUT;
         S_OUT:   state_in = S_EMIT;
         S_EMIT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake, memory, multiplier, divider
   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_IDLE: begin
            mem_we = accept && req_op == OP_APPEND && count_ff < CNT_W'(TONE_DEPTH);
         end
         S_FETCH: mem_re = 1'b1;
         S_READ: begin
            mul_a = 32'(rate_ff);
            mul_b = 32'(rd_dur_ff);
         end
         S_LEN: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(prod_ff[33:0]) + DIV_W'(MS_ROUND);
            div_divisor  = MS_PER_S;
         end
         S_LENW: begin
            // phase step = round(f * 2^PB / rate)
            div_start    = div_stat.done && len_val != '0;
            div_dividend = DIV_W'({rd_freq_ff, {PB{1'b0}}}) + DIV_W'(rate_ff[17:1]);
            div_divisor  = rate_ff;
         end
         S_SAMP: begin
            mul_a = HALF_PI_Q30;
            mul_b = 32'(rarg);
         end
         S_X2M: begin
            mul_a = term_ff;
            mul_b = term_ff;
         end
         S_TM: begin
            mul_a = term_ff;
            mul_b = x2_ff;
         end
         S_TD: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(prod_ff[63:30]);
            div_divisor  = 18'(series_div(n_ff));
         end
         S_MAG: begin
            mul_a = sum_ff[33] ? 32'd0 : sum_ff[31:0];
            mul_b = 32'(SINE_PEAK);
         end
         S_VOL: begin
            mul_a = 32'(mag_ff);
            mul_b = 32'(vol_eff);
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in      = count_ff;
      pidx_in       = pidx_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      left_in       = left_ff;
      playing_in    = playing_ff;
      silent_in     = silent_ff;
      quad_in       = quad_ff;
      x2_in         = x2_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      mag_in        = mag_ff;
      res_sample_in = res_sample_ff;
      res_done_in   = res_done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_done_in   = rsp_done_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_CLEAR:  count_in = '0;
                  OP_APPEND: if (mem_we) count_in = count_ff + 1'b1;
                  OP_START: begin
                     acc_in     = '0;
                     pidx_in    = '0;
                     left_in    = '0;
                     step_in    = '0;
                     silent_in  = 1'b0;
                     playing_in = 1'b1;
                  end
                  OP_ABORT: begin
                     if (playing_ff) begin
                        playing_in    = 1'b0;
                        left_in       = '0;
                        res_sample_in = '0;
                        res_done_in   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            if (pidx_ff >= count_ff) begin
               // list exhausted
               playing_in    = 1'b0;
               res_sample_in = '0;
               res_done_in   = 1'b1;
            end
         end
         S_READ: begin
            pidx_in = pidx_ff + 1'b1;
            if (rd_freq_ff == '0 && rd_dur_ff == '0) begin
               // end-of-list marker
               playing_in    = 1'b0;
               res_sample_in = '0;
               res_done_in   = 1'b1;
            end
         end
         S_LENW: begin
            if (div_stat.done && len_val != '0) begin
               left_in   = len_val;
               silent_in = (rd_freq_ff == '0);
            end
         end
         S_STEPW: if (div_stat.done) step_in = div_quotient[PB-1:0];
         S_SAMP: begin
            quad_in = sidx[SB-1 -: 2];
            if (silent_ff) begin
               left_in       = left_ff - 1'b1;
               res_sample_in = '0;
               res_done_in   = 1'b0;
            end
         end
         S_X: begin
            term_in = prod_ff[SB+31:SB];
            sum_in  = 34'(prod_ff[SB+31:SB]);
         end
         S_X2: begin
            x2_in = prod_ff[61:30];
            n_in  = 3'd1;
         end
         S_TW: begin
            if (div_stat.done) begin
               term_in = div_quotient[31:0];
               sum_in  = n_ff[0] ? sum_ff - $signed({2'b00, div_quotient[31:0]})
                                 : sum_ff + $signed({2'b00, div_quotient[31:0]});
               n_in    = n_ff + 1'b1;
            end
         end
         S_MAG2: mag_in = mag_res;
         S_OUT: begin
            res_sample_in = quad_ff[1] ? 16'(-$signed({1'b0, prod_ff[30:16]}))
                                       : {1'b0, prod_ff[30:16]};
            res_done_in   = 1'b0;
            acc_in        = acc_ff + step_ff;
            left_in       = left_ff - 1'b1;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_done_in   = res_done_ff;
            end
         end
         default: ;
      endcase
   end

   // tone list: write on append, registered read on fetch
   always_ff @(posedge clock) begin
      if (mem_we) begin
         freq_mem[count_ff[IDX_W-1:0]] <= req_freq_hz;
         dur_mem[count_ff[IDX_W-1:0]]  <= req_length_ms;
      end
      if (mem_re) begin
         rd_freq_ff <= freq_mem[pidx_ff[IDX_W-1:0]];
         rd_dur_ff  <= dur_mem[pidx_ff[IDX_W-1:0]];
      end
   end

   // shared multiplier, registered product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      quad_ff       <= quad_in;
      x2_ff         <= x2_in;
      term_ff       <= term_in;
      sum_ff        <= sum_in;
      n_ff          <= n_in;
      mag_ff        <= mag_in;
      res_sample_ff <= res_sample_in;
      res_done_ff   <= res_done_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pidx_ff      <= '0;
         acc_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         playing_ff   <= 1'b0;
         silent_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
         vol_ff       <= VOL_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pidx_ff      <= pidx_in;
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         playing_ff   <= playing_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_RATE) rate_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_VOLUME) vol_ff <= csr_wdata[16:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample   = rsp_sample_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

/* verif/tssg_checker.sv */
// checker for the tone sequence sine generator: predicts samples and compares rsp beats
`timescale 1ns / 1ps
module tssg_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [15:0]        req_freq_hz,
   input  logic [15:0]        req_length_ms,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_sample,
   input  logic               rsp_done_res,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [17:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   import tssg_pkg::*;

   localparam int DEPTH = 64;

   logic [17:0] rate;
   logic [16:0] vol;
   logic [15:0] freq_tab [DEPTH];
   logic [15:0] dur_tab [DEPTH];
   int unsigned tone_cnt;
   int unsigned play_pos;
   logic [31:0] phase_acc;
   logic [31:0] tone_step;
   logic [23:0] left;
   bit          playing;
   bit          silent;

   logic signed [15:0] sample_q [$];
   logic               done_q [$];

   // round(32767 * sin(2 pi k / 4096)) by a q30 series
   function automatic logic signed [15:0] sine_point(input logic [11:0] k);
      logic [63:0] q, r, x, x2, term, mag;
      logic [1:0]  quad;
      longint      sum;
      q = 64'(k) * 4;
      quad = q[13:12];
      r = q % 4096;
      if (quad[0]) r = 4096 - r;
      x = 64'(HALF_PI_Q30) * r / 4096;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      mag = (64'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (mag > 32767) mag = 32767;
      return quad[1] ? -16'(mag) : 16'(mag);
   endfunction

   // walk the list to the next playable tone; 0 ends playback
   function automatic bit load_tone();
      logic [63:0] f, d, len;
      while (play_pos < tone_cnt && play_pos < DEPTH) begin
         f = 64'(freq_tab[play_pos]);
         d = 64'(dur_tab[play_pos]);
         play_pos++;
         if (f == 0 && d == 0) return 0;
         len = (64'(rate) * d + 500) / 1000;
         if (len > 64'hFFFFFF) len = 64'hFFFFFF;
         if (len != 0) begin
            if (rate == 0) tone_step = '0;
            else tone_step = 32'(((f << 32) + 64'(rate) / 2) / 64'(rate));
            silent = (f == 0);
            left = 24'(len);
            return 1;
         end
      end
      return 0;
   endfunction

   task automatic predict_beat(input logic [2:0] op, input logic [15:0] f,
                               input logic [15:0] d);
      logic signed [15:0] v;
      logic [63:0]        mag, vv;
      logic [16:0]        abs_v;
      case (op)
         OP_CLEAR: tone_cnt = 0;
         OP_APPEND: if (tone_cnt < DEPTH) begin
            freq_tab[tone_cnt] = f;
            dur_tab[tone_cnt] = d;
            tone_cnt++;
         end
         OP_START: begin
            phase_acc = '0;
            play_pos = 0;
            left = '0;
            tone_step = '0;
            silent = 0;
            playing = 1;
         end
         OP_ABORT: if (playing) begin
            playing = 0;
            left = '0;
            sample_q.push_back('0);
            done_q.push_back(1'b1);
         end
         OP_TICK: if (playing) begin
            if (left == 0 && !load_tone()) begin
               playing = 0;
               sample_q.push_back('0);
               done_q.push_back(1'b1);
            end else begin
               v = '0;
               if (!silent) begin
                  vv = (vol > VOL_FULL) ? 64'(VOL_FULL) : 64'(vol);
                  v = sine_point(phase_acc[31:20]);
                  abs_v = (v < 0) ? 17'(-v) : 17'(v);
                  mag = (64'(abs_v) * vv) >> 16;
                  v = (v < 0) ? -16'(mag) : 16'(mag);
                  phase_acc = phase_acc + tone_step;
               end
               left--;
               sample_q.push_back(v);
               done_q.push_back(1'b0);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rate = RATE_RESET;
         vol = VOL_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            freq_tab[i] = '0;
            dur_tab[i] = '0;
         end
         tone_cnt = 0;
         play_pos = 0;
         phase_acc = '0;
         tone_step = '0;
         left = '0;
         playing = 0;
         silent = 0;
         fail_count = 0;
         sample_q.delete();
         done_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RATE) rate = csr_wdata;
            else vol = csr_wdata[16:0];
         end
         if (req_valid && !req_stall)
            predict_beat(req_op, req_freq_hz, req_length_ms);
         if (rsp_valid && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               $display("%0t: unexpected beat sample %0d done %0b", $realtime,
                        rsp_sample, rsp_done_res);
               fail_count++;
            end else begin
               if (rsp_sample !== sample_q[0]) begin
                  $display("%0t: sample expected %0d actual %0d", $realtime,
                           sample_q[0], rsp_sample);
                  fail_count++;
               end
               if (rsp_done_res !== done_q[0]) begin
                  $display("%0t: done_res expected %0b actual %0b", $realtime,
                           done_q[0], rsp_done_res);
                  fail_count++;
               end
               void'(sample_q.pop_front());
               void'(done_q.pop_front());
            end
         end
      end
      pending = sample_q.size();
   end

endmodule

/* verif/tb.sv */
// top of the tone sequence sine generator testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;
   import tssg_pkg::*;

   // op codes the block ignores
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [17:0] RATE_MAX = 18'h3FFFF;
   localparam logic [17:0] VOL_OVER = 18'h1FFFF;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_op;
   logic [15:0]        req_freq_hz;
   logic [15:0]        req_length_ms;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_sample;
   logic               rsp_done_res;
   logic               csr_we;
   logic               csr_index;
   logic [17:0]        csr_wdata;
   int                 fail_count;
   int                 pending;

   int  beats_sent;
   bit  quiet;     // last stretch: no idling on either side
   bit  gaps_on;   // sender idles only in some phases

   tone_sequence_sine_generator_top dut (.*);

   tssg_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver stall bursts
   initial begin
      int hold;
      bit stall_now;
      rsp_stall = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            stall_now = !quiet && $urandom_range(0, 2) == 0;
            hold = stall_now ? $urandom_range(1, 12) : $urandom_range(1, 20);
            rsp_stall <= stall_now;
         end else begin
            hold--;
         end
      end
   end

   // one command beat; returns just after the accepting edge
   task automatic send(input logic [2:0] op, input logic [15:0] f, input logic [15:0] d);
      bit taken;
      @(negedge clock);
      if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_freq_hz <= f;
      req_length_ms <= d;
      taken = 0;
      while (!taken) begin
         #1;
         taken = !req_stall;
         @(posedge clock);
         if (!taken) @(negedge clock);
      end
      beats_sent++;
   endtask

   // wait until every expected beat is back and the block has settled
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [17:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic ticks(input int n);
      repeat (n) send(OP_TICK, 16'($urandom), 16'($urandom));
   endtask

   // one random playlist: rate, optional volume and clear, appends, start, ticks with noise, optional abort
   task automatic play_phase();
      int  tones, n;
      logic [15:0] f, d;
      logic [17:0] r;
      gaps_on = $urandom_range(0, 2) != 0;
      drain();
      case ($urandom_range(0, 9))
         0: r = 18'd0;
         1: r = RATE_MAX;
         2: r = 18'd8000;
         default: r = 18'($urandom_range(1, 8000));
      endcase
      write_csr(CSR_RATE, r);
      case ($urandom_range(0, 5))
         0: write_csr(CSR_VOLUME, 18'd0);
         1: write_csr(CSR_VOLUME, 18'(VOL_FULL));
         2: write_csr(CSR_VOLUME, VOL_OVER);
         3: write_csr(CSR_VOLUME, 18'($urandom_range(0, 131071)));
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0) send(OP_CLEAR, 16'($urandom), 16'($urandom));
      tones = ($urandom_range(0, 14) == 0) ? 68 : $urandom_range(1, 5);
      for (int i = 0; i < tones; i++) begin
         case ($urandom_range(0, 5))
            0: f = '0;
            1: f = 16'hFFFF;
            default: f = 16'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0: d = 16'($urandom);
            1: d = '0;
            default: d = 16'($urandom_range(1, 2));
         endcase
         if ($urandom_range(0, 19) == 0) begin
            f = '0;
            d = '0;   // end-of-list marker
         end
         send(OP_APPEND, f, d);
      end
      send(OP_START, 16'($urandom), 16'($urandom));
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0)
            send(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
         else
            send(OP_TICK, 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 1) == 0) send(OP_ABORT, '0, '0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_freq_hz = '0;
      req_length_ms = '0;
      csr_we = 1'b0;
      csr_index = CSR_RATE;
      csr_wdata = '0;
      beats_sent = 0;
      quiet = 0;
      gaps_on = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick / abort, spare ops, then a short mixed playlist
      write_csr(CSR_RATE, 18'd8000);
      send(OP_TICK, '0, '0);
      send(OP_ABORT, '0, '0);
      send(OP_SPARE_LO, 16'hFFFF, 16'hFFFF);
      send(OP_SPARE_HI, '0, '0);
      send(OP_APPEND, 16'd1000, 16'd1);
      send(OP_APPEND, '0, 16'd1);         // silent tone
      send(OP_APPEND, 16'd440, '0);       // zero length, skipped
      send(OP_APPEND, 16'hFFFF, 16'd1);   // above the sample rate
      send(OP_APPEND, '0, '0);            // end marker
      send(OP_START, '0, '0);
      ticks(4);
      send(OP_START, '0, '0);             // restart while playing
      ticks(3);
      send(OP_CLEAR, '0, '0);             // current tone plays out
      ticks(9);

      // saturated tone length at the top rate, full, oversized and zero volume
      drain();
      write_csr(CSR_RATE, RATE_MAX);
      write_csr(CSR_VOLUME, 18'(VOL_FULL));
      send(OP_APPEND, 16'd12345, 16'hFFFF);
      send(OP_START, '0, '0);
      ticks(2);
      drain();
      write_csr(CSR_VOLUME, VOL_OVER);
      ticks(2);
      drain();
      write_csr(CSR_VOLUME, 18'd0);
      ticks(1);
      send(OP_ABORT, '0, '0);

      // zero sample rate: every tone skipped
      drain();
      write_csr(CSR_RATE, 18'd0);
      write_csr(CSR_VOLUME, 18'(VOL_RESET));
      send(OP_START, '0, '0);
      send(OP_TICK, '0, '0);

      // random playlists; the first pauses until all beats are back
      while (beats_sent < 820) play_phase();
      drain();
      quiet = 1;
      while (beats_sent < 950) play_phase();

      drain();
      if (fail_count == 0)
         $display("tone_sequence_sine_generator_top verification clean");
      else
         $display("tone_sequence_sine_generator_top verification failed");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("tone_sequence_sine_generator_top verification failed");
      $finish;
   end

endmodule

/* tone_sequence_sine_generator_top.f */
sv/tssg_pkg.sv
sv/tssg_div.sv
sv/tone_sequence_sine_generator_top.sv
verif/tssg_checker.sv
verif/tb.sv
